>>> design/srbp_pkg.sv
// ----------------------------------------------------------------------------
// srbp_pkg: shared constants for the RRIP replacement engine
// Default geometry, field widths, reset values of the control registers and
// the register index codes of the configuration port.
// ----------------------------------------------------------------------------
package srbp_pkg;

    localparam int unsigned NUM_SETS_DEF  = 2048;
    localparam int unsigned NUM_WAYS_DEF  = 16;
    localparam int unsigned SIG_BITS_DEF  = 6;
    localparam int unsigned ADDR_BITS_DEF = 48;

    // fixed widths of the port fields
    localparam int unsigned SET_IN_W  = 11;
    localparam int unsigned WAY_IN_W  = 4;
    localparam int unsigned ADDR_IN_W = 48;
    localparam int unsigned SIG_IN_W  = 6;
    localparam int unsigned LIMIT_W   = 48;
    localparam int unsigned RUN_W     = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [1:0]       RV_DISTANT = 2'd3;
    localparam logic [1:0]       RRPV_NEAR  = 2'd0;
    localparam logic [1:0]       REUSE_MAX  = 2'd3;
    localparam logic [1:0]       REUSE_INIT = 2'd1;
    localparam logic [RUN_W-1:0] RUN_SAT    = 8'd255;

    localparam logic [RUN_W-1:0]   RUN_LIMIT_RST    = 8'd4;
    localparam logic [LIMIT_W-1:0] STRIDE_LIMIT_RST = 48'd512;
    localparam logic [1:0]         REUSE_THR_RST    = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RUN_LIMIT    = 2'd0,
        CFG_STRIDE_LIMIT = 2'd1,
        CFG_REUSE_THR    = 2'd2
    } t_cfg_idx;

endpackage

>>> design/srbp_alu.sv
// ----------------------------------------------------------------------------
// srbp_alu: shared subtractor
// One wide subtract with sign flag, time-shared for the stride delta, its
// magnitude and the stride limit compare.
// ----------------------------------------------------------------------------
module srbp_alu import srbp_pkg::*; #(
    parameter int unsigned W = 50
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic [W-1:0] o_diff,
    output logic         o_neg
);

    assign o_diff = i_a - i_b;
    assign o_neg  = o_diff[W-1];

endmodule

>>> design/ship_rrip_stream_bypass_policy.sv
// ----------------------------------------------------------------------------
// ship_rrip_stream_bypass_policy: SRRIP victim selection with signature
// reuse insertion and per-set stream bypass
// A victim request reads the set and scans it, ageing the set and scanning
// again when no way is distant. An update forms the stride delta, magnitude
// and limit compare on one shared subtractor; a fill that is not bypassed
// then reads the reuse counter and inserts. A request whose set (or update
// way) is out of range skips the tables. One item at a time: ready returns
// the cycle after the result is loaded. After reset a clearing pass over all
// table entries initialises the tables; no input beat is taken meanwhile.
// ----------------------------------------------------------------------------
module ship_rrip_stream_bypass_policy import srbp_pkg::*; #(
    parameter int unsigned NUM_SETS  = NUM_SETS_DEF,
    parameter int unsigned NUM_WAYS  = NUM_WAYS_DEF,
    parameter int unsigned SIG_BITS  = SIG_BITS_DEF,
    parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_opcode,
    input  logic [SET_IN_W-1:0]  i_set_index,
    input  logic [WAY_IN_W-1:0]  i_way_index,
    input  logic                 i_is_hit,
    input  logic [ADDR_IN_W-1:0] i_phys_addr,
    input  logic [SIG_IN_W-1:0]  i_pc_signature,
    input  logic                 i_victim_valid,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [WAY_IN_W-1:0]  o_victim_way,
    output logic                 o_bypassed,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LIMIT_W-1:0]   i_cfg_data
);

    localparam int unsigned SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int unsigned WAY_W  = $clog2(NUM_WAYS);
    localparam int unsigned SIG_N  = 1 << SIG_BITS;
    localparam int unsigned AB     = ADDR_BITS;
    localparam int unsigned DW     = ADDR_BITS + 1;
    localparam int unsigned SX_W   = (SET_W > SET_IN_W) ? SET_W : SET_IN_W;
    localparam int unsigned WX_W   = (WAY_W > WAY_IN_W) ? WAY_W : WAY_IN_W;
    localparam int unsigned AX_W   = (AB > ADDR_IN_W) ? AB : ADDR_IN_W;
    localparam int unsigned GX_W   = (SIG_BITS > SIG_IN_W) ? SIG_BITS : SIG_IN_W;
    localparam int unsigned ST_ROW = AB + DW + RUN_W;
    localparam int unsigned CLR_N  = (NUM_SETS > SIG_N) ? NUM_SETS : SIG_N;
    localparam int unsigned CLR_W  = $clog2(CLR_N);
    localparam int unsigned AW     = (DW > LIMIT_W) ? DW : LIMIT_W;
    localparam int unsigned ALU_W  = AW + 1;

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_READ   = 11'b000_0000_0100,
        S_VSCAN  = 11'b000_0000_1000,
        S_VSCAN2 = 11'b000_0001_0000,
        S_UDELTA = 11'b000_0010_0000,
        S_UMAG   = 11'b000_0100_0000,
        S_UCMP   = 11'b000_1000_0000,
        S_URD    = 11'b001_0000_0000,
        S_UINS   = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } t_state;

    typedef logic [NUM_WAYS-1:0][1:0]          t_rv_row;
    typedef logic [NUM_WAYS-1:0][SIG_BITS-1:0] t_sg_row;

    // tables
    t_rv_row           m_rv [NUM_SETS];
    t_sg_row           m_sg [NUM_SETS];
    logic [ST_ROW-1:0] m_st [NUM_SETS];
    logic [1:0]        m_ru [SIG_N];

    t_state             r_state, n_state;
    logic [CLR_W-1:0]   r_clr;
    logic               r_op;
    logic [SET_W-1:0]   r_set;
    logic [WAY_W-1:0]   r_way;
    logic               r_hit;
    logic               r_vv;
    logic [AB-1:0]      r_addr;
    logic [SIG_BITS-1:0] r_sig;
    logic [DW-1:0]      r_delta, n_delta;
    logic [DW-1:0]      r_mag, n_mag;
    logic [RUN_W-1:0]   r_run, n_run;
    logic [WAY_IN_W-1:0] r_way_out, n_way_out;
    logic               r_byp, n_byp;
    logic               r_o_valid;
    logic [WAY_IN_W-1:0] r_o_way;
    logic               r_o_byp;
    logic [RUN_W-1:0]   r_run_limit;
    logic [LIMIT_W-1:0] r_stride_limit;
    logic [1:0]         r_reuse_thr;

    t_rv_row            r_rv_row;
    t_sg_row            r_sg_row;
    logic [ST_ROW-1:0]  r_st_row;
    logic [1:0]         r_reuse_q;

    logic [SX_W-1:0]    set_x;
    logic [WX_W-1:0]    way_x;
    logic [AX_W-1:0]    addr_x;
    logic [GX_W-1:0]    sig_x;
    logic               set_ok, way_ok, in_acc, out_acc, load_out, clr_done;

    logic               row_re, age_ld;
    logic               rv_we, sg_we, st_we, ru_we, ru_re;
    logic [SET_W-1:0]   row_waddr;
    t_rv_row            rv_wdata, rv_aged, rv_mod;
    t_sg_row            sg_wdata;
    logic [ST_ROW-1:0]  st_wdata;
    logic [SIG_BITS-1:0] ru_waddr, ru_raddr;
    logic [1:0]         ru_wdata;

    logic               found;
    logic [WAY_W-1:0]   found_idx;
    logic [SIG_BITS-1:0] old_sig;
    logic [AB-1:0]      prev_addr;
    logic [DW-1:0]      prev_delta;
    logic [RUN_W-1:0]   last_run;
    logic               stride_eq, streaming;

    logic [ALU_W-1:0]   alu_a, alu_b, alu_y;
    logic               alu_neg;

    srbp_alu #(.W(ALU_W)) u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_diff (alu_y),
        .o_neg  (alu_neg)
    );

    assign set_x    = SX_W'(i_set_index);
    assign way_x    = WX_W'(i_way_index);
    assign addr_x   = AX_W'(i_phys_addr);
    assign sig_x    = GX_W'(i_pc_signature);
    assign set_ok   = 32'(i_set_index) < NUM_SETS;
    assign way_ok   = 32'(i_way_index) < NUM_WAYS;
    assign in_acc   = i_in_valid && o_in_ready;
    assign out_acc  = r_o_valid && i_out_ready;
    assign load_out = (r_state == S_OUT) && (!r_o_valid || i_out_ready);
    assign clr_done = r_clr == CLR_W'(CLR_N - 1);

    assign o_in_ready   = r_state == S_IDLE;
    assign o_out_valid  = r_o_valid;
    assign o_victim_way = r_o_way;
    assign o_bypassed   = r_o_byp;
    assign o_cfg_ready  = 1'b1;

    assign old_sig = r_sg_row[r_way];
    assign {prev_addr, prev_delta, last_run} = r_st_row;
    assign stride_eq = (r_delta != '0) && (r_delta == prev_delta);
    assign streaming = (r_run >= r_run_limit) || alu_neg;

    // first distant way, and the row aged by one
    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (r_rv_row[w] == RV_DISTANT) begin
                found     = 1'b1;
                found_idx = WAY_W'(w);
            end
        end
    end

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            rv_aged[w] = (r_rv_row[w] == RV_DISTANT) ? RV_DISTANT : r_rv_row[w] + 2'd1;
        end
    end

    // operand select for the shared subtractor
    always_comb begin
        case (r_state)
            S_UMAG: begin
                alu_a = '0;
                alu_b = ALU_W'(r_delta);
            end
            S_UCMP: begin
                alu_a = ALU_W'(r_stride_limit);
                alu_b = ALU_W'(r_mag);
            end
            default: begin
                alu_a = ALU_W'(r_addr);
                alu_b = ALU_W'(prev_addr);
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_delta   = r_delta;
        n_mag     = r_mag;
        n_run     = r_run;
        n_way_out = r_way_out;
        n_byp     = r_byp;
        row_re    = 1'b0;
        age_ld    = 1'b0;
        rv_we     = 1'b0;
        sg_we     = 1'b0;
        st_we     = 1'b0;
        ru_we     = 1'b0;
        ru_re     = 1'b0;
        row_waddr = r_set;
        rv_mod    = r_rv_row;
        rv_wdata  = r_rv_row;
        sg_wdata  = r_sg_row;
        st_wdata  = {r_addr, r_delta, r_run};
        ru_waddr  = old_sig;
        ru_raddr  = old_sig;
        ru_wdata  = r_reuse_q;
        case (r_state)
            S_CLEAR: begin
                row_waddr = r_clr[SET_W-1:0];
                rv_we     = 32'(r_clr) < NUM_SETS;
                sg_we     = rv_we;
                st_we     = rv_we;
                rv_wdata  = {NUM_WAYS{RV_DISTANT}};
                sg_wdata  = '0;
                st_wdata  = '0;
                ru_we     = 32'(r_clr) < SIG_N;
                ru_waddr  = r_clr[SIG_BITS-1:0];
                ru_wdata  = REUSE_INIT;
                if (clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_way_out = '0;
                    n_byp     = 1'b0;
                    if (!set_ok || (i_opcode && !way_ok)) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                row_re  = 1'b1;
                n_state = r_op ? S_UDELTA : S_VSCAN;
            end
            S_VSCAN: begin
                if (found) begin
                    n_way_out = WAY_IN_W'(found_idx);
                    n_state   = S_OUT;
                end else begin
                    rv_we    = 1'b1;
                    rv_wdata = rv_aged;
                    age_ld   = 1'b1;
                    n_state  = S_VSCAN2;
                end
            end
            S_VSCAN2: begin
                n_way_out = found ? WAY_IN_W'(found_idx) : '0;
                n_state   = S_OUT;
            end
            S_UDELTA: begin
                n_delta = (prev_addr != '0) ? alu_y[DW-1:0] : '0;
                ru_re   = 1'b1;
                n_state = S_UMAG;
            end
            S_UMAG: begin
                n_mag = r_delta[DW-1] ? alu_y[DW-1:0] : r_delta;
                if (stride_eq) begin
                    n_run = (last_run == RUN_SAT) ? RUN_SAT : last_run + 8'd1;
                end else begin
                    n_run = '0;
                end
                st_we    = 1'b1;
                st_wdata = {r_addr, r_delta, n_run};
                n_state  = S_UCMP;
            end
            S_UCMP: begin
                if (streaming && !r_hit) begin
                    rv_mod[r_way] = RV_DISTANT;
                    rv_wdata      = rv_mod;
                    rv_we         = 1'b1;
                    n_byp         = 1'b1;
                    n_state       = S_OUT;
                end else if (r_hit) begin
                    rv_mod[r_way] = RRPV_NEAR;
                    rv_wdata      = rv_mod;
                    rv_we         = 1'b1;
                    ru_we         = 1'b1;
                    ru_wdata      = (r_reuse_q == REUSE_MAX) ? REUSE_MAX : r_reuse_q + 2'd1;
                    n_state       = S_OUT;
                end else begin
                    // drop the evicted block's counter before the insertion reads it
                    ru_we           = r_vv && (r_reuse_q != 2'd0);
                    ru_wdata        = r_reuse_q - 2'd1;
                    sg_wdata[r_way] = r_sig;
                    sg_we           = 1'b1;
                    n_state         = S_URD;
                end
            end
            S_URD: begin
                ru_re    = 1'b1;
                ru_raddr = r_sig;
                n_state  = S_UINS;
            end
            S_UINS: begin
                rv_mod[r_way] = (r_reuse_q >= r_reuse_thr) ? RRPV_NEAR : RV_DISTANT;
                rv_wdata      = rv_mod;
                rv_we         = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // tables: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (rv_we) begin
            m_rv[row_waddr] <= rv_wdata;
        end
        if (row_re) begin
            r_rv_row <= m_rv[r_set];
        end else if (age_ld) begin
            r_rv_row <= rv_aged;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sg_we) begin
            m_sg[row_waddr] <= sg_wdata;
        end
        if (row_re) begin
            r_sg_row <= m_sg[r_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            m_st[row_waddr] <= st_wdata;
        end
        if (row_re) begin
            r_st_row <= m_st[r_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ru_we) begin
            m_ru[ru_waddr] <= ru_wdata;
        end
        if (ru_re) begin
            r_reuse_q <= m_ru[ru_raddr];
        end
    end

    // payload of the item in flight
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_opcode;
            r_set  <= set_x[SET_W-1:0];
            r_way  <= way_x[WAY_W-1:0];
            r_hit  <= i_is_hit;
            r_vv   <= i_victim_valid;
            r_addr <= addr_x[AB-1:0];
            r_sig  <= sig_x[SIG_BITS-1:0];
        end
        r_delta   <= n_delta;
        r_mag     <= n_mag;
        r_run     <= n_run;
        r_way_out <= n_way_out;
        r_byp     <= n_byp;
        if (load_out) begin
            r_o_way <= r_way_out;
            r_o_byp <= r_byp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_o_valid      <= 1'b0;
            r_run_limit    <= RUN_LIMIT_RST;
            r_stride_limit <= STRIDE_LIMIT_RST;
            r_reuse_thr    <= REUSE_THR_RST;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + CLR_W'(1);
            end
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (out_acc) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RUN_LIMIT:    r_run_limit    <= i_cfg_data[RUN_W-1:0];
                    CFG_STRIDE_LIMIT: r_stride_limit <= i_cfg_data;
                    CFG_REUSE_THR:    r_reuse_thr    <= i_cfg_data[1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

>>> design/srbp_checker.sv
// ----------------------------------------------------------------------------
// srbp_checker: port-level checks for the replacement engine
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module srbp_checker import srbp_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [WAY_IN_W-1:0] o_victim_way,
    input logic                o_bypassed
);

    // a result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_victim_way)
            && $stable(o_bypassed))
        else $error("result beat dropped or changed while stalled");

    // a bypassed update never names a way
    a_byp_way: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bypassed |-> o_victim_way == '0)
        else $error("bypass result with nonzero way");

    // busy after taking a request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while another is in flight");

    // no result in the cycle right after a request
    a_min_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result appeared too early");

endmodule

bind ship_rrip_stream_bypass_policy srbp_checker u_srbp_checker (.*);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for ship_rrip_stream_bypass_policy
// Drives victim and update requests with random gaps on both channels,
// predicts every result from a behavioural copy of the replacement tables
// and compares each result beat in order. Control registers are rewritten
// between phases while the engine is idle.
// ----------------------------------------------------------------------------
module tb;
    import srbp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETS = 2048;
    localparam int WAYS = 16;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [3:0] way;
        logic       byp;
    } t_result;

    class policy_scoreboard;
        logic [1:0]  rrpv[SETS*WAYS];
        logic [5:0]  bsig[SETS*WAYS];
        logic [1:0]  reuse[64];
        logic [47:0] prev_addr[SETS];
        logic [48:0] last_dlt[SETS];
        logic [7:0]  run_cnt[SETS];
        logic [7:0]  run_limit;
        logic [47:0] stride_lim;
        logic [1:0]  reuse_thr;
        t_result     pending[$];
        int          errors;
        int          checked;

        function new();
            foreach (rrpv[i]) begin
                rrpv[i] = RV_DISTANT;
                bsig[i] = '0;
            end
            foreach (reuse[i]) reuse[i] = REUSE_INIT;
            foreach (prev_addr[i]) begin
                prev_addr[i] = '0;
                last_dlt[i]  = '0;
                run_cnt[i]   = '0;
            end
            run_limit  = RUN_LIMIT_RST;
            stride_lim = STRIDE_LIMIT_RST;
            reuse_thr  = REUSE_THR_RST;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [47:0] d);
            case (idx)
                CFG_RUN_LIMIT:    run_limit  = d[7:0];
                CFG_STRIDE_LIMIT: stride_lim = d;
                CFG_REUSE_THR:    reuse_thr  = d[1:0];
                default: ;
            endcase
        endfunction

        function bit stream_seen(int s, logic [47:0] a);
            logic [48:0] dl;
            logic [48:0] mag;
            dl = '0;
            if (prev_addr[s] != 0) dl = {1'b0, a} - {1'b0, prev_addr[s]};
            if (dl != 0 && dl == last_dlt[s]) begin
                if (run_cnt[s] != 8'd255) run_cnt[s]++;
            end else begin
                run_cnt[s] = '0;
            end
            last_dlt[s]  = dl;
            prev_addr[s] = a;
            mag = dl[48] ? -dl : dl;
            return run_cnt[s] >= run_limit || mag > {1'b0, stride_lim};
        endfunction

        function void note_request(logic op, logic [10:0] s, logic [3:0] w, logic hit,
                                   logic [47:0] a, logic [5:0] sg, logic vv);
            t_result r;
            int b, ix;
            logic [5:0] os;
            bit found;
            r = '0;
            b = int'(s) * WAYS;
            if (!op) begin
                found = 0;
                for (int k = 0; k < WAYS; k++)
                    if (!found && rrpv[b+k] == RV_DISTANT) begin
                        r.way = 4'(k); found = 1;
                    end
                if (!found) begin
                    for (int k = 0; k < WAYS; k++)
                        if (rrpv[b+k] != RV_DISTANT) rrpv[b+k]++;
                    for (int k = 0; k < WAYS; k++)
                        if (!found && rrpv[b+k] == RV_DISTANT) begin
                            r.way = 4'(k); found = 1;
                        end
                end
            end else begin
                ix = b + int'(w);
                if (stream_seen(int'(s), a) && !hit) begin
                    rrpv[ix] = RV_DISTANT;
                    r.byp = 1;
                end else if (hit) begin
                    os = bsig[ix];
                    rrpv[ix] = RRPV_NEAR;
                    if (reuse[os] != REUSE_MAX) reuse[os]++;
                end else begin
                    os = bsig[ix];
                    if (vv && reuse[os] != 0) reuse[os]--;
                    bsig[ix] = sg;
                    rrpv[ix] = (reuse[sg] >= reuse_thr) ? RRPV_NEAR : RV_DISTANT;
                end
            end
            pending.push_back(r);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d (beat %0d)", what, got, want, checked);
            errors++;
        endtask

        task check_result(logic [3:0] way, logic byp);
            t_result e;
            if (pending.size() == 0) begin
                report("unexpected result beat", int'(way), -1);
            end else begin
                e = pending.pop_front();
                if (way !== e.way) report("victim_way", int'(way), int'(e.way));
                if (byp !== e.byp) report("bypassed", int'(byp), int'(e.byp));
            end
            checked++;
        endtask
    endclass

    logic        i_clk, i_rst_n;
    logic        i_in_valid, o_in_ready;
    logic        i_opcode, i_is_hit, i_victim_valid;
    logic [10:0] i_set_index;
    logic [3:0]  i_way_index;
    logic [47:0] i_phys_addr;
    logic [5:0]  i_pc_signature;
    logic        o_out_valid, i_out_ready;
    logic [3:0]  o_victim_way;
    logic        o_bypassed;
    logic        i_cfg_valid, o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [47:0] i_cfg_data;

    ship_rrip_stream_bypass_policy dut (.*);

    policy_scoreboard sb;
    bit   calm;
    int   idle_cycles;
    int   sent;
    int   updates, victims, bypasses;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // result side: random stalls, none during the calm stretch
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_victim_way, o_bypassed);
            if (o_bypassed) bypasses++;
        end
        i_out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 16);
    end

    // watchdog: count cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT + 2100) begin
            $display("timeout with %0d results outstanding", sb.pending.size());
            $display("[ship_rrip_stream_bypass_policy] ERROR");
            $finish;
        end
    end

    // valid stays up after the beat until the next request or an idle cycle
    task send_req(logic op, logic [10:0] s, logic [3:0] w, logic hit,
                  logic [47:0] a, logic [5:0] sg, logic vv);
        while (!calm && $urandom_range(99) < 16) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1;
        i_opcode       <= op;
        i_set_index    <= s;
        i_way_index    <= w;
        i_is_hit       <= hit;
        i_phys_addr    <= a;
        i_pc_signature <= sg;
        i_victim_valid <= vv;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(op, s, w, hit, a, sg, vv);
        if (op) updates++; else victims++;
        sent++;
    endtask

    task drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task write_reg(t_cfg_idx idx, logic [47:0] d);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, d);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    // a strided run through one set with a mix of hits and fills
    task stride_run(int len);
        logic [10:0] s;
        logic [47:0] a, st;
        s  = 11'($urandom_range(15));
        a  = 48'({$urandom, $urandom});
        st = ($urandom_range(3) == 0) ? 48'({$urandom, $urandom})
                                      : 48'(int'($urandom_range(1024)) - 512);
        for (int k = 0; k < len; k++) begin
            send_req(1, s, 4'($urandom_range(15)), $urandom_range(2) == 0, a,
                     6'($urandom_range(7)), 1'($urandom_range(1)));
            a = a + st;
        end
    endtask

    task random_phase(int n);
        int k;
        k = 0;
        while (k < n) begin
            case ($urandom_range(9))
                0, 1, 2: begin
                    send_req(0, 11'($urandom_range(15)), 4'($urandom), 1'($urandom),
                             48'({$urandom, $urandom}), 6'($urandom), 1'($urandom));
                    k++;
                end
                3, 4, 5, 6: begin
                    send_req(1, 11'($urandom_range(15)), 4'($urandom), 1'($urandom),
                             {14'h0, 2'($urandom_range(3)), 12'h0,
                              16'($urandom_range(65535)), 4'h0},
                             6'($urandom_range(15)), 1'($urandom));
                    k++;
                end
                7: begin
                    stride_run(6);
                    k += 6;
                end
                default: begin
                    send_req(1'($urandom), 11'($urandom), 4'($urandom), 1'($urandom),
                             48'({$urandom, $urandom}), 6'($urandom), 1'($urandom));
                    k++;
                end
            endcase
        end
    endtask

    initial begin
        sb = new();
        calm = 0;
        sent = 0; updates = 0; victims = 0; bypasses = 0;
        i_rst_n = 0; i_in_valid = 0; i_out_ready = 0; i_cfg_valid = 0;
        i_opcode = 0; i_set_index = 0; i_way_index = 0; i_is_hit = 0;
        i_phys_addr = 0; i_pc_signature = 0; i_victim_valid = 0;
        i_cfg_index = CFG_RUN_LIMIT; i_cfg_data = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty set, ageing, extremes of each field
        send_req(0, 0, 0, 0, 0, 0, 0);
        for (int w = 0; w < 16; w++)
            send_req(1, 1, 4'(w), 1, 48'h1000 + 48'(w * 64), 6'(w), 0);
        send_req(0, 1, 0, 0, 0, 0, 0);
        send_req(0, 1, 0, 0, 0, 0, 0);
        send_req(0, 11'h7FF, 4'hF, 1, 48'hFFFF_FFFF_FFFF, 6'h3F, 1);
        send_req(1, 11'h7FF, 4'hF, 0, 48'hFFFF_FFFF_FFFF, 6'h3F, 1);
        send_req(1, 11'h7FF, 4'h0, 0, 48'h0, 6'h3F, 1);
        send_req(1, 2, 3, 0, 48'h2000, 6'h3F, 1);
        send_req(1, 2, 3, 0, 48'h2040, 6'h3F, 1);
        drain();

        write_reg(CFG_RUN_LIMIT, 0);
        write_reg(CFG_STRIDE_LIMIT, 0);
        write_reg(CFG_REUSE_THR, 0);
        random_phase(150);
        drain();

        write_reg(CFG_RUN_LIMIT, 255);
        write_reg(CFG_STRIDE_LIMIT, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_REUSE_THR, 3);
        calm = 1;
        random_phase(250);
        calm = 0;
        drain();

        write_reg(CFG_RUN_LIMIT, 1);
        write_reg(CFG_STRIDE_LIMIT, 48'h10000);
        write_reg(CFG_REUSE_THR, 1);
        random_phase(400);
        drain();

        write_reg(CFG_RUN_LIMIT, 4);
        write_reg(CFG_STRIDE_LIMIT, 512);
        write_reg(CFG_REUSE_THR, 2);
        random_phase(580);
        drain();

        $display("%0d requests: %0d victim, %0d update, %0d fills bypassed",
                 sent, victims, updates, bypasses);
        $display("%0d result beats checked over four register settings", sb.checked);
        if (sb.errors == 0)
            $display("[ship_rrip_stream_bypass_policy] OK");
        else
            $display("[ship_rrip_stream_bypass_policy] ERROR");
        $finish;
    end
endmodule

>>> files.f
design/srbp_pkg.sv
design/srbp_alu.sv
design/ship_rrip_stream_bypass_policy.sv
design/srbp_checker.sv
tb/tb.sv
